// ===== rtl/rwt_pkg.sv =====
package rwt_pkg;

	// Default sizes of the window and of the byte ring.
	localparam int RWT_WINDOW_SLOTS = 16;
	localparam int RWT_RING_BYTES   = 512;

	// Field widths fixed by the item format.
	localparam int SEQ_W      = 8;
	localparam int LEN_W      = 8;
	localparam int OFFSET_W   = 9;
	localparam int AGE_W      = 8;
	localparam int SLOT_TAB_W = 7;

	localparam logic [AGE_W-1:0] AGE_RESET = 8'd8;

	// Register indexes on the configuration port.
	localparam logic REG_RETRANSMIT_AGE = 1'b0;

	// Event codes carried in the input tuser.
	localparam logic [1:0] MODE_SEND = 2'd0;
	localparam logic [1:0] MODE_ACK  = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEND,
		ST_ACK,
		ST_WALK_RD,
		ST_WALK,
		ST_TICK_RD,
		ST_TICK,
		ST_ZERO
	} rwt_state_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_SEND,
		RES_ACK,
		RES_TICK
	} res_kind_t;

	typedef enum logic [1:0] {
		CUR_TAIL,
		CUR_ACK,
		CUR_HEAD
	} cur_sel_t;

	typedef struct packed {
		logic      accept;
		cur_sel_t  cur_sel;
		logic      inc_cur;
		logic      send_commit;
		logic      ack_mark;
		logic      walk_step;
		logic      tick_hit;
		logic      tick_miss;
		logic      res_load;
		res_kind_t res_kind;
	} rwt_cmd_t;

	typedef struct packed {
		logic out_free;
		logic window_empty;
		logic send_ok;
		logic ack_in_range;
		logic ack_is_head;
		logic walk_end;
		logic slot_done;
		logic tick_due;
		logic tick_last;
	} rwt_status_t;

	typedef logic [255:0][SLOT_TAB_W-1:0] slot_tab_t;

	// Sequence number to slot index, built by counting so that no division is needed.
	function automatic slot_tab_t slot_table(input int slots);
		slot_tab_t t;
		logic [SLOT_TAB_W-1:0] r;
		r = '0;
		for (int i = 0; i < 256; i++) begin
			t[i] = r;
			if (r == SLOT_TAB_W'(slots - 1)) begin
				r = '0;
			end else begin
				r = r + SLOT_TAB_W'(1);
			end
		end
		return t;
	endfunction

endpackage

// ===== rtl/rwt_ctrl.sv =====
module rwt_ctrl
	import rwt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic [1:0]  mode,
	input  rwt_status_t status,
	output logic        s_tready,
	output rwt_cmd_t    cmd
);

	rwt_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					unique case (mode)
						MODE_SEND: state_d = ST_SEND;
						MODE_ACK:  state_d = ST_ACK;
						MODE_TICK: state_d = status.window_empty ? ST_ZERO : ST_TICK_RD;
						default:   state_d = ST_ZERO;
					endcase
				end
			end
			ST_SEND: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			ST_ACK: begin
				if (status.out_free) begin
					state_d = (status.ack_in_range && status.ack_is_head) ? ST_WALK_RD : ST_IDLE;
				end
			end
			ST_WALK_RD: state_d = ST_WALK;
			ST_WALK: begin
				state_d = (status.walk_end || !status.slot_done) ? ST_IDLE : ST_WALK_RD;
			end
			ST_TICK_RD: state_d = ST_TICK;
			ST_TICK: begin
				if (status.tick_due || status.tick_last) begin
					if (status.out_free) state_d = ST_IDLE;
				end else begin
					state_d = ST_TICK_RD;
				end
			end
			ST_ZERO: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		cmd      = '0;
		cmd.cur_sel  = CUR_TAIL;
		cmd.res_kind = RES_ZERO;
		unique case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
				unique case (mode)
					MODE_ACK:  cmd.cur_sel = CUR_ACK;
					MODE_TICK: cmd.cur_sel = CUR_HEAD;
					default:   cmd.cur_sel = CUR_TAIL;
				endcase
			end
			ST_SEND: begin
				if (status.out_free) begin
					cmd.res_load    = 1'b1;
					cmd.send_commit = status.send_ok;
					cmd.res_kind    = status.send_ok ? RES_SEND : RES_ZERO;
				end
			end
			ST_ACK: begin
				if (status.out_free) begin
					cmd.res_load = 1'b1;
					if (status.ack_in_range) begin
						cmd.res_kind = RES_ACK;
						cmd.ack_mark = 1'b1;
						cmd.inc_cur  = status.ack_is_head;
					end
				end
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
				cmd.inc_cur   = !status.walk_end && status.slot_done;
			end
			ST_TICK: begin
				if (status.tick_due) begin
					if (status.out_free) begin
						cmd.res_load = 1'b1;
						cmd.res_kind = RES_TICK;
						cmd.tick_hit = 1'b1;
					end
				end else if (status.tick_last) begin
					if (status.out_free) begin
						cmd.res_load  = 1'b1;
						cmd.tick_miss = 1'b1;
					end
				end else begin
					cmd.inc_cur = 1'b1;
				end
			end
			ST_ZERO: begin
				cmd.res_load = status.out_free;
			end
			default: begin
				cmd.res_load = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/rwt_datapath.sv =====
module rwt_datapath
	import rwt_pkg::*;
#(
	parameter int WINDOW_SLOTS = RWT_WINDOW_SLOTS,
	parameter int RING_BYTES   = RWT_RING_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rwt_cmd_t            cmd,
	input  logic [SEQ_W-1:0]    in_ack_seq,
	input  logic [LEN_W-1:0]    in_packet_length,
	input  logic [AGE_W-1:0]    cfg_age,
	input  logic                m_tready,
	output rwt_status_t         status,
	output logic                m_tvalid,
	output logic                res_ok,
	output logic [SEQ_W-1:0]    res_seq,
	output logic [OFFSET_W-1:0] res_offset,
	output logic [LEN_W-1:0]    res_length
);

	localparam int SW   = $clog2(WINDOW_SLOTS);
	localparam int RW   = $clog2(RING_BYTES);
	localparam int CW   = RW + 1;
	localparam int CNTW = $clog2(WINDOW_SLOTS + 1);
	localparam slot_tab_t SLOT_TAB = slot_table(WINDOW_SLOTS);

	logic [SEQ_W-1:0]  head_q, tail_q, clock_q;
	logic [RW-1:0]     rhead_q, rtail_q;
	logic [SEQ_W-1:0]  cur_q, cur_d;
	logic [SW-1:0]     slot_q, slot_d;
	logic [CNTW-1:0]   cnt_q;
	logic [LEN_W-1:0]  len_q;
	logic              out_valid_q;

	// Slot memory, one array per field with a shared registered read.
	logic              mem_done   [WINDOW_SLOTS];
	logic [SEQ_W-1:0]  mem_stamp  [WINDOW_SLOTS];
	logic [RW-1:0]     mem_offset [WINDOW_SLOTS];
	logic [LEN_W-1:0]  mem_length [WINDOW_SLOTS];
	logic              rd_done_q;
	logic [SEQ_W-1:0]  rd_stamp_q;
	logic [RW-1:0]     rd_offset_q;
	logic [LEN_W-1:0]  rd_length_q;

	logic [SEQ_W-1:0]      used;
	logic [SEQ_W-1:0]      ack_dist;
	logic [SEQ_W-1:0]      age_now;
	logic [SLOT_TAB_W-1:0] tab_entry;
	logic [CW-1:0]         cap;
	logic [CW-1:0]         sum;
	logic [RW-1:0]         place_off;
	logic [RW-1:0]         base_tail;
	logic [RW-1:0]         new_tail;

	assign used     = tail_q - head_q;
	assign ack_dist = cur_q - head_q;
	assign age_now  = clock_q - rd_stamp_q;

	// Placement of a new region: behind the tail, or wrapped to the ring start.
	always_comb begin
		if (used == '0) begin
			cap       = CW'(RING_BYTES);
			place_off = '0;
			base_tail = '0;
		end else begin
			place_off = rtail_q;
			base_tail = rtail_q;
			if (rhead_q >= rtail_q) begin
				cap = CW'(rhead_q) - CW'(rtail_q);
			end else begin
				cap = CW'(RING_BYTES) - CW'(rtail_q);
				if (cap < CW'(len_q)) begin
					place_off = '0;
					cap       = CW'(rhead_q);
					base_tail = '0;
				end
			end
		end
		sum      = CW'(base_tail) + CW'(len_q);
		new_tail = (sum >= CW'(RING_BYTES)) ? '0 : sum[RW-1:0];
	end

	always_comb begin
		status.out_free     = !out_valid_q || m_tready;
		status.window_empty = (head_q == tail_q);
		status.send_ok      = (used < SEQ_W'(WINDOW_SLOTS)) && (cap >= CW'(len_q));
		status.ack_in_range = (ack_dist < used);
		status.ack_is_head  = (cur_q == head_q);
		status.walk_end     = (cur_q == tail_q);
		status.slot_done    = rd_done_q;
		status.tick_due     = !rd_done_q && (age_now >= cfg_age);
		status.tick_last    = ((cur_q + SEQ_W'(1)) == tail_q) ||
			((cnt_q + CNTW'(1)) == CNTW'(WINDOW_SLOTS));
	end

	always_comb begin
		case (cmd.cur_sel)
			CUR_ACK:  cur_d = in_ack_seq;
			CUR_HEAD: cur_d = head_q;
			default:  cur_d = tail_q;
		endcase
		if (!cmd.accept) cur_d = cur_q + SEQ_W'(1);
		tab_entry = SLOT_TAB[cur_d];
		slot_d    = tab_entry[SW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept || cmd.inc_cur) begin
			cur_q  <= cur_d;
			slot_q <= slot_d;
		end
		if (cmd.accept) begin
			cnt_q <= '0;
			len_q <= in_packet_length;
		end else if (cmd.inc_cur) begin
			cnt_q <= cnt_q + CNTW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			rhead_q <= '0;
			rtail_q <= '0;
			clock_q <= '0;
		end else begin
			if (cmd.send_commit) begin
				if (used == '0) rhead_q <= '0;
				rtail_q <= new_tail;
				tail_q  <= tail_q + SEQ_W'(1);
			end
			if (cmd.walk_step) begin
				head_q <= cur_q;
				if (cur_q == tail_q) begin
					rhead_q <= '0;
					rtail_q <= '0;
				end else begin
					rhead_q <= rd_offset_q;
				end
			end
			if (cmd.tick_miss) clock_q <= clock_q + SEQ_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.send_commit) begin
			mem_done[slot_q]   <= 1'b0;
			mem_stamp[slot_q]  <= clock_q;
			mem_offset[slot_q] <= place_off;
			mem_length[slot_q] <= len_q;
		end
		if (cmd.ack_mark) mem_done[slot_q] <= 1'b1;
		if (cmd.tick_hit) mem_stamp[slot_q] <= clock_q;
		rd_done_q   <= mem_done[slot_q];
		rd_stamp_q  <= mem_stamp[slot_q];
		rd_offset_q <= mem_offset[slot_q];
		rd_length_q <= mem_length[slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			case (cmd.res_kind)
				RES_SEND: begin
					res_ok     <= 1'b1;
					res_seq    <= tail_q;
					res_offset <= OFFSET_W'(place_off);
					res_length <= len_q;
				end
				RES_ACK: begin
					res_ok     <= 1'b1;
					res_seq    <= '0;
					res_offset <= '0;
					res_length <= '0;
				end
				RES_TICK: begin
					res_ok     <= 1'b1;
					res_seq    <= cur_q;
					res_offset <= OFFSET_W'(rd_offset_q);
					res_length <= rd_length_q;
				end
				default: begin
					res_ok     <= 1'b0;
					res_seq    <= '0;
					res_offset <= '0;
					res_length <= '0;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

// ===== rtl/retransmit_window_tracker_core.sv =====
// Send, unused event code and tick on an empty window: the result is registered once the
// output is free. Ack: likewise, and an ack of the head then moves it past each acked slot.
// Tick: up to WINDOW_SLOTS slots are scanned, each with a read of the single-port slot memory
// and then a test of that slot. One event is handled at a time.
// Reset clears the pointers, the retransmit clock and the output valid, and sets the age to 8;
// the slot memory is not cleared, as no slot is read before a send has written it.
module retransmit_window_tracker_core
	import rwt_pkg::*;
#(
	parameter int WINDOW_SLOTS = RWT_WINDOW_SLOTS,
	parameter int RING_BYTES   = RWT_RING_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // ack_seq [7:0], packet_length [15:8]
	input  logic [1:0]  s_tuser,   // mode [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // out_seq [7:0], buffer_offset [16:8], out_length [24:17]
	output logic [0:0]  m_tuser,   // ok [0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	rwt_cmd_t            cmd;
	rwt_status_t         status;
	logic [AGE_W-1:0]    age_q;
	logic                res_ok;
	logic [SEQ_W-1:0]    res_seq;
	logic [OFFSET_W-1:0] res_offset;
	logic [LEN_W-1:0]    res_length;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= AGE_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_RETRANSMIT_AGE)) begin
			age_q <= pwdata[AGE_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_RETRANSMIT_AGE) ? {24'd0, age_q} : 32'd0;

	rwt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.mode     (s_tuser),
		.status   (status),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	rwt_datapath #(
		.WINDOW_SLOTS (WINDOW_SLOTS),
		.RING_BYTES   (RING_BYTES)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.in_ack_seq       (s_tdata[7:0]),
		.in_packet_length (s_tdata[15:8]),
		.cfg_age          (age_q),
		.m_tready         (m_tready),
		.status           (status),
		.m_tvalid         (m_tvalid),
		.res_ok           (res_ok),
		.res_seq          (res_seq),
		.res_offset       (res_offset),
		.res_length       (res_length)
	);

	assign m_tdata = {7'd0, res_length, res_offset, res_seq};
	assign m_tuser = res_ok;

endmodule

// ===== rtl/rwt_checker.sv =====
module rwt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [0:0]  m_tuser,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata
);

	// A stalled result must hold still.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	else $error("stalled result changed");

	// A refused event or an empty tick carries no sequence, offset or length.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 32'd0)
	else $error("result without ok carries data");

	// Only one event is in hand at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
	else $error("second event taken while one is in progress");

	// The age register reads back what was last written.
	assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && !paddr[2] |=>
		paddr[2] || prdata[7:0] == $past(pwdata[7:0]))
	else $error("age register read-back mismatch");

endmodule

bind retransmit_window_tracker_core rwt_checker u_rwt_checker (.*);

// ===== sim/retransmit_window_tracker_checker.sv =====
module retransmit_window_tracker_checker
	import rwt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // ack_seq [7:0], packet_length [15:8]
	input  logic [1:0]  s_tuser,   // mode [1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // out_seq [7:0], buffer_offset [16:8], out_length [24:17]
	input  logic [0:0]  m_tuser,   // ok [0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          error_count,
	output int          reports_pending,
	output int          reports_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] AGE_ADDR = {REG_RETRANSMIT_AGE, 2'b00};

	typedef struct packed {
		logic                ok;
		logic [SEQ_W-1:0]    seq;
		logic [OFFSET_W-1:0] offset;
		logic [LEN_W-1:0]    length;
	} report_t;

	report_t expected_reports[$];
	report_t want;
	report_t got;
	int      mismatches;

	// Own copy of the window state.
	logic [AGE_W-1:0]    age_limit;
	logic [SEQ_W-1:0]    win_head;
	logic [SEQ_W-1:0]    win_tail;
	int                  ring_rd;
	int                  ring_wr;
	logic [7:0]          rt_clock;
	logic                acked[RWT_WINDOW_SLOTS];
	logic [7:0]          stamp[RWT_WINDOW_SLOTS];
	logic [OFFSET_W-1:0] region_off[RWT_WINDOW_SLOTS];
	logic [LEN_W-1:0]    region_len[RWT_WINDOW_SLOTS];

	function automatic int slot_index(input logic [SEQ_W-1:0] s);
		return int'(s) % RWT_WINDOW_SLOTS;
	endfunction

	function automatic report_t claim_slot(input logic [LEN_W-1:0] len);
		report_t r;
		int      used;
		int      cap;
		int      off;
		int      wr_next;
		int      k;
		r = '0;
		used = int'(8'(win_tail - win_head));
		if (used >= RWT_WINDOW_SLOTS) begin
			return r;
		end
		if (used == 0) begin
			ring_rd = 0;
			ring_wr = 0;
			cap = RWT_RING_BYTES;
			off = 0;
			wr_next = 0;
		end else begin
			off = ring_wr;
			wr_next = ring_wr;
			if (ring_rd >= ring_wr) begin
				cap = ring_rd - ring_wr;
			end else begin
				cap = RWT_RING_BYTES - ring_wr;
				// Too little room before the end of the ring: try again from offset zero.
				if (cap < int'(len)) begin
					off = 0;
					cap = ring_rd;
					wr_next = 0;
				end
			end
		end
		if (cap < int'(len)) begin
			return r;
		end
		wr_next = wr_next + int'(len);
		if (wr_next >= RWT_RING_BYTES) begin
			wr_next = 0;
		end
		ring_wr = wr_next;
		k = slot_index(win_tail);
		region_off[k] = OFFSET_W'(off);
		region_len[k] = len;
		acked[k] = 1'b0;
		stamp[k] = rt_clock;
		r.ok = 1'b1;
		r.seq = win_tail;
		r.offset = OFFSET_W'(off);
		r.length = len;
		win_tail = win_tail + 8'd1;
		return r;
	endfunction

	function automatic report_t mark_acked(input logic [SEQ_W-1:0] s);
		report_t          r;
		logic [SEQ_W-1:0] p;
		int               used;
		r = '0;
		used = int'(8'(win_tail - win_head));
		if (int'(8'(s - win_head)) >= used) begin
			return r;
		end
		acked[slot_index(s)] = 1'b1;
		r.ok = 1'b1;
		if (s == win_head) begin
			p = s;
			for (int n = 0; n <= RWT_WINDOW_SLOTS; n++) begin
				p = p + 8'd1;
				win_head = p;
				if (p == win_tail) begin
					ring_rd = 0;
					ring_wr = 0;
					break;
				end
				ring_rd = int'(region_off[slot_index(p)]);
				if (!acked[slot_index(p)]) begin
					break;
				end
			end
		end
		return r;
	endfunction

	function automatic report_t scan_due();
		report_t          r;
		logic [SEQ_W-1:0] h;
		int               k;
		r = '0;
		if (win_head == win_tail) begin
			return r;
		end
		h = win_head;
		for (int n = 0; n < RWT_WINDOW_SLOTS && h != win_tail; n++) begin
			k = slot_index(h);
			if (!acked[k] && 8'(rt_clock - stamp[k]) >= age_limit) begin
				stamp[k] = rt_clock;
				r.ok = 1'b1;
				r.seq = h;
				r.offset = region_off[k];
				r.length = region_len[k];
				return r;
			end
			h = h + 8'd1;
		end
		rt_clock = rt_clock + 8'd1;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_limit = AGE_RESET;
			win_head = '0;
			win_tail = '0;
			ring_rd = 0;
			ring_wr = 0;
			rt_clock = '0;
			for (int i = 0; i < RWT_WINDOW_SLOTS; i++) begin
				acked[i] = 1'b0;
				stamp[i] = '0;
				region_off[i] = '0;
				region_len[i] = '0;
			end
			expected_reports.delete();
			error_count = 0;
			mismatches = 0;
			reports_pending = 0;
			reports_checked = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == AGE_ADDR) begin
				age_limit = pwdata[AGE_W-1:0];
			end
			// The result side is handled first, since a result always belongs to an older transfer.
			if (m_tvalid && m_tready) begin
				got.ok = m_tuser[0];
				got.seq = m_tdata[7:0];
				got.offset = m_tdata[16:8];
				got.length = m_tdata[24:17];
				if (expected_reports.size() == 0) begin
					error_count++;
					if (mismatches < 10) begin
						$display("%0t: result with nothing expected: ok %0b seq %0d off %0d len %0d",
							$realtime, got.ok, got.seq, got.offset, got.length);
					end
					mismatches++;
				end else begin
					want = expected_reports.pop_front();
					reports_checked++;
					if (got.ok !== want.ok || got.seq !== want.seq ||
						got.offset !== want.offset || got.length !== want.length) begin
						error_count++;
						if (mismatches < 10) begin
							$display("%0t: result %0d expected ok %0b seq %0d off %0d len %0d",
								$realtime, reports_checked, want.ok, want.seq, want.offset,
								want.length);
							$display("%0t: result %0d actual   ok %0b seq %0d off %0d len %0d",
								$realtime, reports_checked, got.ok, got.seq, got.offset,
								got.length);
						end
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					MODE_SEND: want = claim_slot(s_tdata[15:8]);
					MODE_ACK:  want = mark_acked(s_tdata[7:0]);
					MODE_TICK: want = scan_due();
					default:   want = '0;
				endcase
				expected_reports.push_back(want);
			end
			reports_pending = expected_reports.size();
		end
	end

endmodule

// ===== sim/retransmit_window_tracker_core_tb.sv =====
module retransmit_window_tracker_core_tb;
	import rwt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] AGE_ADDR      = {REG_RETRANSMIT_AGE, 2'b00};
	localparam logic [1:0] MODE_UNUSED   = 2'd3;
	localparam int         HOLD_CYCLES   = 400;
	localparam int         QUIET_LIMIT   = 5000;
	localparam int         SETTLE_CYCLES = 40;
	localparam int         PHASE_EVENTS  = 215;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // ack_seq [7:0], packet_length [15:8]
	logic [1:0]  s_tuser;   // mode [1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // out_seq [7:0], buffer_offset [16:8], out_length [24:17]
	logic [0:0]  m_tuser;   // ok [0]
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int error_count;
	int reports_pending;
	int reports_checked;

	// Sender-side record of the window, used only to steer acks and sends.
	logic [7:0] track_head;
	logic [7:0] track_tail;
	logic       track_acked[256];

	logic steady;
	logic hold_req;
	logic hold_done;
	int   quiet_cycles;
	int   events_sent;
	int   sends_sent;
	int   acks_sent;
	int   ticks_sent;
	int   settings_used;

	retransmit_window_tracker_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	retransmit_window_tracker_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pready          (pready),
		.error_count     (error_count),
		.reports_pending (reports_pending),
		.reports_checked (reports_checked)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int idle_length();
		int r;
		if (steady) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] track_used();
		return 8'(track_tail - track_head);
	endfunction

	// Result side: random back-pressure, and one long hold once the request is raised.
	initial begin
		int hold;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				hold = HOLD_CYCLES;
				hold_done = 1'b1;
			end else begin
				hold = idle_length();
			end
			if (hold > 0) begin
				m_tready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(negedge clk);
		end
	end

	// Offers one event and returns at the falling edge after its transfer, valid still high.
	task automatic push_event(input logic [1:0] mode, input logic [7:0] seq,
		input logic [7:0] len);
		int gap;
		gap = idle_length();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {len, seq};
		do begin
			@(posedge clk);
		end while (!s_tready);
		@(negedge clk);
		if (mode != MODE_UNUSED) begin
			events_sent++;
		end
	endtask

	task automatic send_event(input logic [7:0] len, input logic taken);
		push_event(MODE_SEND, 8'($urandom_range(0, 255)), len);
		sends_sent++;
		if (taken) begin
			track_acked[track_tail] = 1'b0;
			track_tail = track_tail + 8'd1;
		end
	endtask

	task automatic ack_event(input logic [7:0] seq);
		push_event(MODE_ACK, seq, 8'($urandom_range(0, 255)));
		acks_sent++;
		if (8'(seq - track_head) < track_used()) begin
			track_acked[seq] = 1'b1;
			while (track_head != track_tail && track_acked[track_head]) begin
				track_head = track_head + 8'd1;
			end
		end
	endtask

	task automatic tick_event();
		push_event(MODE_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		ticks_sent++;
	endtask

	// Lets the block go idle: no transfer offered, every result in, and the ack walk finished.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (reports_pending != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		settings_used++;
	endtask

	task automatic drain_window();
		logic [7:0] used;
		while (track_used() != 0) begin
			used = track_used();
			if ($urandom_range(0, 1) == 0) begin
				ack_event(track_head);
			end else begin
				ack_event(8'(track_head + 8'($urandom_range(0, int'(used) - 1))));
			end
		end
	endtask

	// From an empty window: two large regions, free the first, wrap the next region to offset
	// zero, then ask for more than the gap up to the head so that the send finds no room.
	task automatic ring_episode();
		int a;
		int b;
		int c;
		int d;
		a = $urandom_range(200, 255);
		b = $urandom_range(200, 255);
		send_event(8'(a), 1'b1);
		send_event(8'(b), 1'b1);
		ack_event(track_head);
		if ($urandom_range(0, 1) == 0) begin
			// Exact fit up to the end of the ring.
			send_event(8'(512 - a - b), 1'b1);
		end
		c = $urandom_range(513 - a - b, a);
		send_event(8'(c), 1'b1);
		d = $urandom_range(a - c + 1, 255);
		send_event(8'(d), 1'b0);
		drain_window();
	endtask

	// Small regions never run out of ring room, so only a full window rejects a send here.
	task automatic random_traffic(input int budget);
		int         count;
		int         r;
		logic [7:0] used;
		count = 0;
		while (count < budget) begin
			if (count % 64 == 63) begin
				steady = ($urandom_range(0, 3) == 0);
			end
			used = track_used();
			r = $urandom_range(0, 99);
			if (r < 35) begin
				if (used < 8'(RWT_WINDOW_SLOTS)) begin
					send_event(8'($urandom_range(1, 24)), 1'b1);
				end else begin
					send_event(8'($urandom_range(0, 255)), 1'b0);
				end
			end else if (r < 62) begin
				if (used != 0) begin
					ack_event(8'(track_head + 8'($urandom_range(0, int'(used) - 1))));
				end else begin
					ack_event(8'($urandom_range(0, 255)));
				end
			end else if (r < 85) begin
				tick_event();
			end else if (r < 94) begin
				ack_event(8'($urandom_range(0, 255)));
			end else begin
				push_event(MODE_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				count--;
			end
			count++;
		end
		drain_window();
	endtask

	initial begin
		logic [7:0] ages[6];
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = MODE_SEND;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		steady = 1'b0;
		hold_req = 1'b0;
		hold_done = 1'b0;
		quiet_cycles = 0;
		events_sent = 0;
		sends_sent = 0;
		acks_sent = 0;
		ticks_sent = 0;
		settings_used = 0;
		track_head = '0;
		track_tail = '0;
		for (int i = 0; i < 256; i++) begin
			track_acked[i] = 1'b0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset age.
		tick_event();
		push_event(MODE_UNUSED, 8'hFF, 8'hFF);
		ack_event(8'd0);
		send_event(8'd255, 1'b1);
		send_event(8'd255, 1'b1);
		send_event(8'd1, 1'b1);
		send_event(8'd2, 1'b0);
		send_event(8'd0, 1'b1);
		ack_event(8'd200);
		ack_event(8'd2);
		ack_event(8'd2);
		ack_event(8'd0);
		repeat (9) tick_event();
		ack_event(8'd1);
		ack_event(8'd3);
		settle();

		ages[0] = 8'd1;
		ages[1] = 8'd0;
		ages[2] = 8'd255;
		ages[3] = 8'($urandom_range(2, 20));
		ages[4] = 8'($urandom_range(2, 254));
		ages[5] = AGE_RESET;
		for (int p = 0; p < 6; p++) begin
			write_register(AGE_ADDR, {24'd0, ages[p]});
			if (p == 0) begin
				// Keep offering transfers while the result side is held off.
				steady = 1'b1;
				hold_req = 1'b1;
			end else begin
				steady = 1'b0;
			end
			ring_episode();
			random_traffic(PHASE_EVENTS);
			settle();
		end

		$display("Covered %0d events (%0d sends, %0d acks, %0d ticks) and %0d checked results,",
			events_sent, sends_sent, acks_sent, ticks_sent, reports_checked);
		$display("over %0d age settings with one %0d-cycle hold-off on the result side.",
			settings_used + 1, HOLD_CYCLES);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
